@@ rtl/tmwf_pkg.sv @@
// Package with the constants, types and control structures of the trimmed mean window filter.
package tmwf_pkg;

	localparam int WINDOW_DEPTH = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int KEEP_COUNT = 4;
	localparam int FIRST_KEPT_RANK = (WINDOW_DEPTH / 2) - 2;
	localparam int NUM_CHANNELS = 3;
	localparam int POS_BITS = $clog2(WINDOW_DEPTH);
	localparam int KEEP_BITS = $clog2(KEEP_COUNT);
	localparam int SUM_BITS = SAMPLE_BITS + KEEP_BITS;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic sort;
		logic phase_odd;
		logic acc_en;
		logic [KEEP_BITS-1:0] acc_idx;
	} lane_ctrl_t;

endpackage

@@ rtl/tmwf_lane.sv @@
// One channel of the filter: sample ring, transposition sorter and trimmed sum accumulator.
module tmwf_lane
	import tmwf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  pos_t       wr_pos,
	input  sample_t    sample,
	output sample_t    mean
);

	sample_t ring_q [WINDOW_DEPTH];
	sample_t sort_q [WINDOW_DEPTH];
	sample_t sort_d [WINDOW_DEPTH];
	logic [SUM_BITS-1:0] acc_q;
	pos_t rd_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (ctrl.load) begin
			ring_q[wr_pos] <= sample;
		end
	end

	// Each phase exchanges disjoint neighbor pairs so that larger values move to lower ranks.
	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			sort_d[i] = sort_q[i];
		end
		for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
			if ((ctrl.phase_odd == 1'(i % 2)) && (sort_q[i] < sort_q[i+1])) begin
				sort_d[i] = sort_q[i+1];
				sort_d[i+1] = sort_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				sort_q[i] <= (pos_t'(i) == wr_pos) ? sample : ring_q[i];
			end
		end else if (ctrl.sort) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				sort_q[i] <= sort_d[i];
			end
		end
	end

	assign rd_idx = pos_t'(FIRST_KEPT_RANK) + pos_t'(ctrl.acc_idx);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + SUM_BITS'(sort_q[rd_idx]);
		end
	end

	assign mean = acc_q[SUM_BITS-1:KEEP_BITS];

endmodule

@@ rtl/trimmed_mean_window_filter_core.sv @@
// Top level of the three channel sliding window trimmed mean filter.
// Each accepted transaction writes one sample per channel into that channel's ring of the last
// eight samples, copies the ring into a sorting register row, and sorts it in descending order
// with eight odd-even transposition phases, one phase per cycle in a shared row of compare and
// exchange cells. The four middle ranks are then summed one by one in a single adder and divided
// by four with truncation. The result register is loaded after the eight sort phases, the
// accumulation of the four middle ranks and a hand-off state, which stretches while an earlier
// result is still waiting. The result is held in an output register, so the next sample
// transaction is accepted while a result waits.
// The rings start at zero after reset, and those zeros take part in the sort until they are
// replaced.
module trimmed_mean_window_filter_core
	import tmwf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t supply_current_sample,
	input  sample_t load_voltage_sample,
	input  sample_t load_current_sample,
	output logic    filtered_valid,
	input  logic    filtered_ready,
	output sample_t supply_current_filtered,
	output sample_t load_voltage_filtered,
	output sample_t load_current_filtered
);

	state_t state_q;
	state_t state_d;
	pos_t cnt_q;
	pos_t cnt_d;
	pos_t pos_q;
	logic out_valid_q;
	logic out_load;
	lane_ctrl_t ctrl;
	sample_t lane_in [NUM_CHANNELS];
	sample_t lane_mean [NUM_CHANNELS];
	sample_t filt_q [NUM_CHANNELS];

	assign lane_in[0] = supply_current_sample;
	assign lane_in[1] = load_voltage_sample;
	assign lane_in[2] = load_current_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		sample_ready = 1'b0;
		out_load = 1'b0;
		ctrl = '0;
		ctrl.phase_odd = cnt_q[0];
		ctrl.acc_idx = cnt_q[KEEP_BITS-1:0];
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					ctrl.load = 1'b1;
					cnt_d = '0;
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				ctrl.sort = 1'b1;
				if (cnt_q == pos_t'(WINDOW_DEPTH - 1)) begin
					cnt_d = '0;
					state_d = ST_SUM;
				end else begin
					cnt_d = cnt_q + pos_t'(1);
				end
			end
			ST_SUM: begin
				ctrl.acc_en = 1'b1;
				if (cnt_q == pos_t'(KEEP_COUNT - 1)) begin
					cnt_d = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + pos_t'(1);
				end
			end
			ST_DONE: begin
				if (!out_valid_q || filtered_ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctrl.load) begin
			if (pos_q >= pos_t'(WINDOW_DEPTH - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (filtered_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
		tmwf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.wr_pos (pos_q),
			.sample (lane_in[c]),
			.mean   (lane_mean[c])
		);

		always_ff @(posedge clk) begin
			if (out_load) begin
				filt_q[c] <= lane_mean[c];
			end
		end
	end

	assign filtered_valid = out_valid_q;
	assign supply_current_filtered = filt_q[0];
	assign load_voltage_filtered = filt_q[1];
	assign load_current_filtered = filt_q[2];

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the three channel trimmed mean window filter core.
module tb
	import tmwf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		sample_t supply_current;
		sample_t load_voltage;
		sample_t load_current;
	} scan_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_ready;
	sample_t supply_current_sample = '0;
	sample_t load_voltage_sample = '0;
	sample_t load_current_sample = '0;
	logic    filtered_valid;
	logic    filtered_ready = 1'b0;
	sample_t supply_current_filtered;
	sample_t load_voltage_filtered;
	sample_t load_current_filtered;

	scan_t   pending_scans[$];
	scan_t   expected_means[$];
	sample_t channel_rings [NUM_CHANNELS][WINDOW_DEPTH];
	pos_t    next_slot;
	scan_t   last_scan;
	int      sender_idle_pct = 0;
	int      receiver_stall_pct = 0;
	int      error_count = 0;

	trimmed_mean_window_filter_core dut (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.sample_valid            (sample_valid),
		.sample_ready            (sample_ready),
		.supply_current_sample   (supply_current_sample),
		.load_voltage_sample     (load_voltage_sample),
		.load_current_sample     (load_current_sample),
		.filtered_valid          (filtered_valid),
		.filtered_ready          (filtered_ready),
		.supply_current_filtered (supply_current_filtered),
		.load_voltage_filtered   (load_voltage_filtered),
		.load_current_filtered   (load_current_filtered)
	);

	always #5 clk = ~clk;

	function automatic sample_t middle_four_mean(input sample_t ring [WINDOW_DEPTH]);
		sample_t             ranked [WINDOW_DEPTH];
		sample_t             held;
		logic [SUM_BITS-1:0] kept_sum;
		int                  j;
		ranked = ring;
		for (int i = 1; i < WINDOW_DEPTH; i++) begin
			held = ranked[i];
			j = i - 1;
			while (j >= 0 && ranked[j] < held) begin
				ranked[j + 1] = ranked[j];
				j--;
			end
			ranked[j + 1] = held;
		end
		kept_sum = '0;
		for (int k = 0; k < KEEP_COUNT; k++) begin
			kept_sum += SUM_BITS'(ranked[FIRST_KEPT_RANK + k]);
		end
		return sample_t'(kept_sum >> KEEP_BITS);
	endfunction

	task automatic record_scan(input scan_t s);
		scan_t means;
		channel_rings[0][next_slot] = s.supply_current;
		channel_rings[1][next_slot] = s.load_voltage;
		channel_rings[2][next_slot] = s.load_current;
		next_slot = (int'(next_slot) == WINDOW_DEPTH - 1) ? '0 : next_slot + 1'b1;
		means.supply_current = middle_four_mean(channel_rings[0]);
		means.load_voltage = middle_four_mean(channel_rings[1]);
		means.load_current = middle_four_mean(channel_rings[2]);
		expected_means.push_back(means);
	endtask

	function automatic sample_t pick_sample(input sample_t prior);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return sample_t'($urandom_range(0, 15));
			3: return sample_t'(16'hFFFF - $urandom_range(0, 15));
			4: return prior;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic queue_scan(input sample_t sc, input sample_t lv, input sample_t lc);
		scan_t s;
		s.supply_current = sc;
		s.load_voltage = lv;
		s.load_current = lc;
		pending_scans.push_back(s);
		last_scan = s;
	endtask

	task automatic queue_random_scans(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_scan(last_scan.supply_current, last_scan.load_voltage,
					last_scan.load_current);
			end else begin
				queue_scan(pick_sample(last_scan.supply_current),
					pick_sample(last_scan.load_voltage),
					pick_sample(last_scan.load_current));
			end
		end
	endtask

	task automatic drain;
		while (pending_scans.size() != 0 || sample_valid) @(posedge clk);
		while (expected_means.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string field, input sample_t want, input sample_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready) begin
				record_scan({supply_current_sample, load_voltage_sample, load_current_sample});
			end
			if (!sample_valid || sample_ready) begin
				if (pending_scans.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					scan_t s;
					s = pending_scans.pop_front();
					supply_current_sample <= s.supply_current;
					load_voltage_sample <= s.load_voltage;
					load_current_sample <= s.load_current;
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			filtered_ready <= 1'b0;
		end else begin
			if (filtered_valid && filtered_ready) begin
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h %h", $time,
						supply_current_filtered, load_voltage_filtered, load_current_filtered);
					error_count++;
				end else begin
					scan_t want;
					want = expected_means.pop_front();
					check_field("supply_current_filtered", want.supply_current,
						supply_current_filtered);
					check_field("load_voltage_filtered", want.load_voltage, load_voltage_filtered);
					check_field("load_current_filtered", want.load_current, load_current_filtered);
				end
			end
			filtered_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	initial begin
		#5ms;
		$display("trimmed_mean_window_filter_core test failed");
		$finish;
	end

	initial begin
		foreach (channel_rings[c, i]) channel_rings[c][i] = '0;
		next_slot = '0;
		last_scan = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 8; i++) queue_scan(16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 4; i++) queue_scan(16'h0000, 16'hFFFF, 16'h0001);
		for (int i = 0; i < 4; i++) begin
			queue_scan(16'hAAAA, 16'h5555, i[0] ? 16'hAAAA : 16'h5555);
		end
		for (int i = 0; i < 4; i++) begin
			queue_scan(sample_t'(i * 16'h1111), sample_t'(16'hFFFF - i), sample_t'(i));
		end
		queue_scan(16'hFFFF, 16'h0000, 16'h8000);
		queue_scan(16'h8000, 16'h7FFF, 16'hFFFE);
		queue_scan(16'h0001, 16'hFFFF, 16'h0000);
		queue_scan(16'h1234, 16'h1234, 16'h1234);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
				default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
			endcase
			queue_random_scans(332);
			drain();
		end

		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("trimmed_mean_window_filter_core test passed");
		end else begin
			$display("trimmed_mean_window_filter_core test failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/tmwf_pkg.sv
rtl/tmwf_lane.sv
rtl/trimmed_mean_window_filter_core.sv
tb/tb.sv
